// ----- rtl/core/fit_record_stream_parser_top_defines.svh -----
// ============================================================================
// FIT record parser assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ============================================================================
`ifndef FIT_RECORD_STREAM_PARSER_TOP_DEFINES_SVH
`define FIT_RECORD_STREAM_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FITP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FITP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fitp_pkg.sv -----
// ============================================================================
// FIT record parser package
// Sizes, register map, event codes, result types and the FIT CRC-16 step.
// ============================================================================
`default_nettype none

package fitp_pkg;

    localparam int MAX_FIELDS   = 32;
    localparam int FLD_W        = $clog2(MAX_FIELDS);
    localparam int LOCAL_TYPES  = 16;
    localparam int TYPE_W       = $clog2(LOCAL_TYPES);
    localparam int TBL_DEPTH    = LOCAL_TYPES * MAX_FIELDS;
    localparam int TBL_AW       = TYPE_W + FLD_W;
    localparam int HEADER_BYTES = 14;
    localparam int RQ_DEPTH     = 4;
    localparam int RQ_AW        = $clog2(RQ_DEPTH);

    // Register indexes on paddr[3:2].
    localparam logic [1:0] REG_TIME_FIELD  = 2'd0;
    localparam logic [1:0] REG_WATCH_MSG   = 2'd1;
    localparam logic [1:0] REG_SPEED_FIELD = 2'd2;

    localparam logic [7:0]  TIME_FIELD_RST  = 8'd4;
    localparam logic [15:0] WATCH_MSG_RST   = 16'd19;
    localparam logic [7:0]  SPEED_FIELD_RST = 8'd13;

    localparam logic [3:0] REC_DEFINITION = 4'h4;
    localparam logic [3:0] REC_DATA       = 4'h0;

    typedef enum logic [2:0] {
        EVT_HDR_OK   = 3'd0,
        EVT_HDR_BAD  = 3'd1,
        EVT_TIME     = 3'd2,
        EVT_SPEED    = 3'd3,
        EVT_DATA_OK  = 3'd4,
        EVT_DATA_BAD = 3'd5
    } t_evt_kind;

    typedef struct packed {
        t_evt_kind   kind;
        logic [63:0] value;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       slot0;
        t_res       slot1;
    } t_res_push;

    function automatic logic [15:0] crc_nib(input logic [3:0] n);
        logic [15:0] v;
        unique case (n)
            4'h0: v = 16'h0000;
            4'h1: v = 16'hCC01;
            4'h2: v = 16'hD801;
            4'h3: v = 16'h1400;
            4'h4: v = 16'hF001;
            4'h5: v = 16'h3C00;
            4'h6: v = 16'h2800;
            4'h7: v = 16'hE401;
            4'h8: v = 16'hA001;
            4'h9: v = 16'h6C00;
            4'hA: v = 16'h7800;
            4'hB: v = 16'hB401;
            4'hC: v = 16'h5000;
            4'hD: v = 16'h9C01;
            4'hE: v = 16'h8801;
            default: v = 16'h4400;
        endcase
        return v;
    endfunction

    // One byte of the FIT CRC, low nibble first.
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = {4'h0, c[15:4]} ^ crc_nib(c[3:0]) ^ crc_nib(b[3:0]);
        x = {4'h0, x[15:4]} ^ crc_nib(x[3:0]) ^ crc_nib(b[7:4]);
        return x;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fitp_res_fifo.sv -----
// ============================================================================
// FIT record parser result queue
// Small queue that takes up to two results a cycle, hands one out when ready.
// ============================================================================
`default_nettype none

`include "fit_record_stream_parser_top_defines.svh"

module fitp_res_fifo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  fitp_pkg::t_res_push    i_push,
    output logic                   o_room,
    output logic                   o_valid,
    output fitp_pkg::t_res         o_res,
    input  wire                    i_ready
);
    import fitp_pkg::*;

    t_res             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp, r_rp;
    logic [RQ_AW:0]   r_cnt;
    logic [RQ_AW:0]   n_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    // Room for the two results the parser may push in one step.
    assign o_room  = (r_cnt <= (RQ_AW+1)'(RQ_DEPTH - 2));

    always_comb begin
        n_cnt = r_cnt + (RQ_AW+1)'(i_push.count) - (RQ_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_wp  <= r_wp + RQ_AW'(i_push.count);
            if (pop) begin
                r_rp <= r_rp + RQ_AW'(1);
            end
        end
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wp + RQ_AW'(1)] <= i_push.slot1;
        end
    end

    `FITP_ASSERT_SAME(a_no_overflow, i_push.count != 2'd0, o_room, "result pushed without room")
    `FITP_ASSERT_SAME(a_cnt_bound, 1'b1, r_cnt <= (RQ_AW+1)'(RQ_DEPTH), "queue count overrun")
    `FITP_ASSERT_NEXT(a_pop_drains, o_valid && i_ready && i_push.count == 2'd0,
                      r_cnt == $past(r_cnt) - (RQ_AW+1)'(1), "pop did not drain")

endmodule

`default_nettype wire

// ----- rtl/core/fitp_parser.sv -----
// ============================================================================
// FIT record parser core
// Header check, record walk and field table, at most one byte a step.
// ============================================================================
`default_nettype none

`include "fit_record_stream_parser_top_defines.svh"

module fitp_parser (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire  [7:0]             i_data_byte,
    input  wire                    i_frame_start,
    output logic                   o_in_ready,
    input  wire  [7:0]             i_time_field,
    input  wire  [15:0]            i_watch_msg,
    input  wire  [7:0]             i_speed_field,
    input  wire                    i_room,
    output fitp_pkg::t_res_push    o_push
);
    import fitp_pkg::*;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_RECHDR  = 7'b0000010,
        PH_DEFN    = 7'b0000100,
        PH_DATAREC = 7'b0001000,
        PH_SKIP    = 7'b0010000,
        PH_FILECRC = 7'b0100000,
        PH_IDLE    = 7'b1000000
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [31:0]  r_bc, n_bc;
    logic [31:0]  r_dlen, n_dlen;
    logic [15:0]  r_crc, n_crc;
    logic [15:0]  r_rcrc, n_rcrc;
    logic [7:0]   r_cnt [LOCAL_TYPES];
    logic [7:0]   n_cnt [LOCAL_TYPES];
    logic [15:0]  r_gnum [LOCAL_TYPES];
    logic [15:0]  n_gnum [LOCAL_TYPES];
    logic [15:0]  r_first [LOCAL_TYPES];
    logic [15:0]  n_first [LOCAL_TYPES];
    logic [TYPE_W-1:0] r_type, n_type;
    logic [7:0]   r_fidx, n_fidx;
    logic [7:0]   r_fbi, n_fbi;
    logic [63:0]  r_acc, n_acc;
    logic         r_time_rep, n_time_rep;
    logic         r_time_v, n_time_v;
    logic [63:0]  r_time, n_time;
    logic         r_speed_v, n_speed_v;
    logic [15:0]  r_speed, n_speed;
    logic [7:0]   r_def_total, n_def_total;
    logic [15:0]  r_cur, n_cur;
    logic         r_end, n_end;

    // Field table: {number, size} per local type and field slot.
    logic [15:0]       mem [TBL_DEPTH];
    logic [15:0]       r_rdata;
    logic              we;
    logic [TBL_AW-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic [TBL_AW-1:0] rd_addr;

    logic      step_byte, step_adv;
    t_res_push push;

    assign o_in_ready = i_room && (r_phase != PH_SKIP);
    assign step_byte  = i_valid && o_in_ready;
    assign step_adv   = i_room && (r_phase == PH_SKIP);
    assign o_push     = push;

    // The read runs one field ahead of the field in progress.
    assign rd_addr = {n_type, n_fidx[FLD_W-1:0] + FLD_W'(1)};

    always_comb begin
        t_phase      ph0;
        logic [7:0]  b;
        logic [31:0] bc0;
        logic [7:0]  k;
        logic [7:0]  sz;
        logic [15:0] ent;
        logic        fd_en;
        logic [7:0]  fd_num;
        logic [63:0] fd_val;
        logic        adv_en;
        logic [7:0]  adv_idx;
        logic [15:0] adv_entry;
        logic        rec_byte;
        logic        emit_t, emit_s;

        n_phase     = r_phase;
        n_bc        = r_bc;
        n_dlen      = r_dlen;
        n_crc       = r_crc;
        n_rcrc      = r_rcrc;
        n_cnt       = r_cnt;
        n_gnum      = r_gnum;
        n_first     = r_first;
        n_type      = r_type;
        n_fidx      = r_fidx;
        n_fbi       = r_fbi;
        n_acc       = r_acc;
        n_time_rep  = r_time_rep;
        n_time_v    = r_time_v;
        n_time      = r_time;
        n_speed_v   = r_speed_v;
        n_speed     = r_speed;
        n_def_total = r_def_total;
        n_cur       = r_cur;
        n_end       = r_end;
        we          = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        push        = '0;
        b           = i_data_byte;
        fd_en       = 1'b0;
        fd_num      = '0;
        fd_val      = '0;
        adv_en      = 1'b0;
        adv_idx     = '0;
        adv_entry   = '0;
        emit_t      = 1'b0;
        emit_s      = 1'b0;
        k           = r_fbi - 8'd5;
        sz          = r_cur[7:0];
        ent         = '0;

        // A frame start restarts the parse before the byte is taken.
        if (step_byte && i_frame_start) begin
            n_phase     = PH_HEADER;
            n_bc        = '0;
            n_dlen      = '0;
            n_crc       = '0;
            n_rcrc      = '0;
            n_cnt       = '{default: '0};
            n_gnum      = '{default: '0};
            n_type      = '0;
            n_fidx      = '0;
            n_fbi       = '0;
            n_acc       = '0;
            n_time_rep  = 1'b0;
            n_time_v    = 1'b0;
            n_time      = '0;
            n_speed_v   = 1'b0;
            n_speed     = '0;
            n_def_total = '0;
            n_end       = 1'b0;
        end
        ph0      = n_phase;
        bc0      = n_bc;
        rec_byte = step_byte &&
                   (ph0 == PH_RECHDR || ph0 == PH_DEFN || ph0 == PH_DATAREC);

        if (step_byte) begin
            unique case (ph0)
                PH_HEADER: begin
                    if (bc0 < 32'(HEADER_BYTES - 2)) begin
                        n_crc = crc_step(n_crc, b);
                    end
                    if (bc0 >= 32'd4 && bc0 < 32'd8) begin
                        n_dlen = n_dlen | ({24'h0, b} << {bc0[1:0], 3'b000});
                    end
                    if (bc0 == 32'(HEADER_BYTES - 2)) begin
                        n_rcrc = {8'h0, b};
                    end else if (bc0 == 32'(HEADER_BYTES - 1)) begin
                        n_rcrc            = {b, n_rcrc[7:0]};
                        push.count        = 2'd1;
                        push.slot0.value  = {48'h0, n_crc};
                        push.slot0.last   = 1'b1;
                        if (n_rcrc == n_crc) begin
                            push.slot0.kind = EVT_HDR_OK;
                            n_crc           = '0;
                            n_rcrc          = '0;
                            n_bc            = '0;
                            n_phase         = (n_dlen == '0) ? PH_FILECRC : PH_RECHDR;
                        end else begin
                            push.slot0.kind = EVT_HDR_BAD;
                            n_phase         = PH_IDLE;
                        end
                    end
                    if (n_phase == PH_HEADER) begin
                        n_bc = bc0 + 32'd1;
                    end
                end
                PH_RECHDR: begin
                    n_crc     = crc_step(n_crc, b);
                    n_type    = b[TYPE_W-1:0];
                    n_time_v  = 1'b0;
                    n_speed_v = 1'b0;
                    n_fidx    = '0;
                    n_fbi     = '0;
                    n_acc     = '0;
                    if (b[7:4] == REC_DEFINITION) begin
                        n_phase = PH_DEFN;
                    end else if (b[7:4] == REC_DATA) begin
                        adv_en    = 1'b1;
                        adv_idx   = 8'd0;
                        adv_entry = r_first[b[TYPE_W-1:0]];
                    end
                end
                PH_DEFN: begin
                    n_crc = crc_step(n_crc, b);
                    if (r_fbi < 8'd5) begin
                        n_fbi = r_fbi + 8'd1;
                        if (r_fbi == 8'd2) begin
                            n_gnum[r_type] = {8'h0, b};
                        end else if (r_fbi == 8'd3) begin
                            n_gnum[r_type] = {b, r_gnum[r_type][7:0]};
                        end else if (r_fbi == 8'd4) begin
                            n_def_total   = b;
                            n_cnt[r_type] = '0;
                            n_fidx        = '0;
                            if (b == 8'd0) begin
                                n_phase = PH_RECHDR;
                                n_fbi   = r_fbi;
                            end
                        end
                    end else if (k == 8'd0) begin
                        n_acc = {56'h0, b};
                        n_fbi = r_fbi + 8'd1;
                    end else if (k == 8'd1) begin
                        if (r_fidx < 8'(MAX_FIELDS)) begin
                            ent           = {r_acc[7:0], b};
                            we            = 1'b1;
                            wr_addr       = {r_type, r_fidx[FLD_W-1:0]};
                            wr_data       = ent;
                            n_cnt[r_type] = r_fidx + 8'd1;
                            if (r_fidx == 8'd0) begin
                                n_first[r_type] = ent;
                            end
                        end
                        n_fbi = r_fbi + 8'd1;
                    end else begin
                        n_fidx = r_fidx + 8'd1;
                        n_fbi  = 8'd5;
                        if (n_fidx >= r_def_total) begin
                            n_phase = PH_RECHDR;
                        end
                    end
                end
                PH_DATAREC: begin
                    n_crc = crc_step(n_crc, b);
                    if (sz <= 8'd8 && r_fbi < 8'd8) begin
                        n_acc = r_acc | ({56'h0, b} << {r_fbi[2:0], 3'b000});
                    end
                    n_fbi = r_fbi + 8'd1;
                    if (n_fbi >= sz) begin
                        fd_en     = 1'b1;
                        fd_num    = r_cur[15:8];
                        fd_val    = (sz <= 8'd8) ? n_acc : 64'h0;
                        adv_en    = 1'b1;
                        adv_idx   = r_fidx + 8'd1;
                        adv_entry = r_rdata;
                    end
                end
                PH_FILECRC: begin
                    if (bc0 == 32'd0) begin
                        n_rcrc = {8'h0, b};
                        n_bc   = 32'd1;
                    end else begin
                        n_rcrc           = {b, r_rcrc[7:0]};
                        push.count       = 2'd1;
                        push.slot0.kind  = (n_rcrc == r_crc) ? EVT_DATA_OK : EVT_DATA_BAD;
                        push.slot0.value = {48'h0, r_crc};
                        push.slot0.last  = 1'b1;
                        n_phase          = PH_IDLE;
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase
        end else if (step_adv) begin
            // Zero-size field: value 0, no byte consumed.
            fd_en     = 1'b1;
            fd_num    = r_cur[15:8];
            fd_val    = 64'h0;
            adv_en    = 1'b1;
            adv_idx   = r_fidx + 8'd1;
            adv_entry = r_rdata;
        end

        if (fd_en) begin
            if (!n_time_rep && !n_time_v && fd_num == i_time_field) begin
                n_time_v = 1'b1;
                n_time   = fd_val;
            end
            if (r_gnum[n_type] == i_watch_msg && !n_speed_v && fd_num == i_speed_field) begin
                n_speed_v = 1'b1;
                n_speed   = fd_val[15:0];
            end
        end

        if (adv_en) begin
            n_fidx = adv_idx;
            if (adv_idx >= r_cnt[n_type]) begin
                emit_t = n_time_v;
                emit_s = n_speed_v;
                if (n_time_v) begin
                    n_time_rep = 1'b1;
                    n_time_v   = 1'b0;
                end
                n_speed_v = 1'b0;
                n_phase   = PH_RECHDR;
            end else begin
                n_cur   = adv_entry;
                n_fbi   = '0;
                n_acc   = '0;
                n_phase = (adv_entry[7:0] == 8'd0) ? PH_SKIP : PH_DATAREC;
            end
        end

        if (emit_t) begin
            push.slot0.kind  = EVT_TIME;
            push.slot0.value = n_time;
            push.slot0.last  = !emit_s;
        end
        if (emit_s) begin
            if (emit_t) begin
                push.slot1.kind  = EVT_SPEED;
                push.slot1.value = {48'h0, n_speed};
                push.slot1.last  = 1'b1;
            end else begin
                push.slot0.kind  = EVT_SPEED;
                push.slot0.value = {48'h0, n_speed};
                push.slot0.last  = 1'b1;
            end
        end
        if (emit_t || emit_s) begin
            push.count = 2'({1'b0, emit_t} + {1'b0, emit_s});
        end

        // End of the data area closes any record in progress.
        if (rec_byte) begin
            n_bc = bc0 + 32'd1;
            if (n_bc >= n_dlen) begin
                if (n_phase == PH_SKIP) begin
                    n_end = 1'b1;
                end else begin
                    n_time_v  = 1'b0;
                    n_speed_v = 1'b0;
                    n_bc      = '0;
                    n_rcrc    = '0;
                    n_phase   = PH_FILECRC;
                end
            end
        end
        if (step_adv && r_end && n_phase != PH_SKIP) begin
            n_time_v  = 1'b0;
            n_speed_v = 1'b0;
            n_bc      = '0;
            n_rcrc    = '0;
            n_end     = 1'b0;
            n_phase   = PH_FILECRC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_bc        <= '0;
            r_dlen      <= '0;
            r_crc       <= '0;
            r_rcrc      <= '0;
            r_cnt       <= '{default: '0};
            r_gnum      <= '{default: '0};
            r_type      <= '0;
            r_fidx      <= '0;
            r_fbi       <= '0;
            r_acc       <= '0;
            r_time_rep  <= 1'b0;
            r_time_v    <= 1'b0;
            r_time      <= '0;
            r_speed_v   <= 1'b0;
            r_speed     <= '0;
            r_def_total <= '0;
            r_end       <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_bc        <= n_bc;
            r_dlen      <= n_dlen;
            r_crc       <= n_crc;
            r_rcrc      <= n_rcrc;
            r_cnt       <= n_cnt;
            r_gnum      <= n_gnum;
            r_type      <= n_type;
            r_fidx      <= n_fidx;
            r_fbi       <= n_fbi;
            r_acc       <= n_acc;
            r_time_rep  <= n_time_rep;
            r_time_v    <= n_time_v;
            r_time      <= n_time;
            r_speed_v   <= n_speed_v;
            r_speed     <= n_speed;
            r_def_total <= n_def_total;
            r_end       <= n_end;
        end
        r_first <= n_first;
        r_cur   <= n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    `FITP_ASSERT_SAME(a_skip_holds_input, r_phase == PH_SKIP, !o_in_ready,
                      "input taken during a field skip")
    `FITP_ASSERT_SAME(a_end_only_in_skip, r_end, r_phase == PH_SKIP,
                      "data end flag outside a field skip")
    `FITP_ASSERT_SAME(a_push_needs_step, o_push.count != 2'd0, step_byte || step_adv,
                      "result without a parse step")

endmodule

`default_nettype wire

// ----- rtl/core/fit_record_stream_parser_top.sv -----
// ============================================================================
// FIT record stream parser
// Byte-stream FIT file parser with header and data CRC check and field report.
// ============================================================================
// The block takes one FIT file byte per word on the slave stream and reports
// events on the master stream: header CRC good or bad, the first time field
// of the file, the speed field of the watched message, and the data CRC
// result. A byte is taken every cycle unless held. Each zero-size field of a
// data record holds the input while the field table is read for the next
// slot, since the table memory gives one entry per cycle and is read one
// field ahead. The input is also held while the result queue has fewer than
// two free words. Results leave at one word per cycle while tready is high;
// tlast marks the last result of one step. Write the three registers through
// the APB port only while the stream is idle; the block does not enforce it.
`default_nettype none

module fit_record_stream_parser_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Slave stream: tdata = data_byte[7:0]; tuser = frame_start.
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,
    input  wire         i_s_axis_tuser,
    // Master stream: tdata = event_value[63:0]; tuser = event_kind[2:0];
    // tlast = last_event.
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    // APB configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fitp_pkg::*;

    logic [7:0]  r_time_field;
    logic [15:0] r_watch_msg;
    logic [7:0]  r_speed_field;
    logic        cfg_wr;
    logic        room;
    t_res_push   push;
    t_res        res;

    // Registers decode on the word index; writes land on the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_field  <= TIME_FIELD_RST;
            r_watch_msg   <= WATCH_MSG_RST;
            r_speed_field <= SPEED_FIELD_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_TIME_FIELD:  r_time_field  <= pwdata[7:0];
                REG_WATCH_MSG:   r_watch_msg   <= pwdata[15:0];
                REG_SPEED_FIELD: r_speed_field <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TIME_FIELD:  prdata = {24'h0, r_time_field};
            REG_WATCH_MSG:   prdata = {16'h0, r_watch_msg};
            REG_SPEED_FIELD: prdata = {24'h0, r_speed_field};
            default:         prdata = '0;
        endcase
    end

    // Parser core: header, record walk and the field table memory.
    fitp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .i_data_byte   (i_s_axis_tdata),
        .i_frame_start (i_s_axis_tuser),
        .o_in_ready    (o_s_axis_tready),
        .i_time_field  (r_time_field),
        .i_watch_msg   (r_watch_msg),
        .i_speed_field (r_speed_field),
        .i_room        (room),
        .o_push        (push)
    );

    // Result queue decouples the two stream sides.
    fitp_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .o_res   (res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = res.value;
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule

`default_nettype wire
